### rtl/cbfe_pkg.sv
// ----------------------------------------------------------------------------
// cbfe_pkg
// Shared types and constants of the complemented byte frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbfe_pkg;

  localparam logic [7:0] PREAMBLE_FIRST  = 8'h55;
  localparam logic [7:0] PREAMBLE_SECOND = 8'hFF;
  localparam logic [7:0] PREAMBLE_THIRD  = 8'h00;

  // command queue between the front and the back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       opens_message;
    logic       closes_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  // one classified byte, with the running sum that includes it
  typedef struct packed {
    in_item_t   item;
    logic [7:0] sum;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage : cbfe_pkg

`default_nettype wire

### rtl/cbfe_front.sv
// ----------------------------------------------------------------------------
// cbfe_front
// Accepts message bytes, keeps the running sum and queues one command per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfe_front import cbfe_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push,
  output logic      full,
  input  in_item_t  in_item_i,
  input  q_status_t q_status_i,
  output logic      cmd_push_o,
  output cmd_t      cmd_o
);

  logic [7:0] sum_q;
  logic [7:0] sum_d;

  assign full       = q_status_i.full;
  assign cmd_push_o = push && !q_status_i.full;

  // restart on the command byte, otherwise accumulate modulo 256
  assign sum_d = in_item_i.opens_message ? in_item_i.data_byte
                                         : sum_q + in_item_i.data_byte;

  assign cmd_o.item = in_item_i;
  assign cmd_o.sum  = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 8'h00;
    end else if (cmd_push_o) begin
      sum_q <= sum_d;
    end
  end

endmodule : cbfe_front

`default_nettype wire

### rtl/cbfe_queue.sv
// ----------------------------------------------------------------------------
// cbfe_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfe_queue import cbfe_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push_i,
  input  cmd_t      cmd_i,
  input  wire       pop_i,
  output cmd_t      head_o,
  output q_status_t status_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule : cbfe_queue

`default_nettype wire

### rtl/cbfe_back.sv
// ----------------------------------------------------------------------------
// cbfe_back
// Steps through the line bytes of each queued command into a registered result
// slot, one per cycle while the slot is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module cbfe_back import cbfe_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  cmd_t      head_i,
  input  q_status_t q_status_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  wire       pop,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_PRE0  = 3'd0,
    S_PRE1  = 3'd1,
    S_PRE2  = 3'd2,
    S_DATA  = 3'd3,
    S_DATAN = 3'd4,
    S_SUM   = 3'd5,
    S_SUMN  = 3'd6
  } step_e;

  step_e     step_q;
  logic      started_q;
  logic      out_valid_q;
  out_item_t out_q;

  step_e     cur_step;
  step_e     last_step;
  logic      is_last;
  logic      emit;
  out_item_t res;

  assign cur_step  = started_q ? step_q
                               : (head_i.item.opens_message ? S_PRE0 : S_DATA);
  assign last_step = head_i.item.closes_message ? S_SUMN : S_DATAN;
  assign is_last   = (cur_step == last_step);
  assign emit      = !q_status_i.empty && (!out_valid_q || pop);
  assign cmd_pop_o = emit && is_last;

  always_comb begin
    res.run_last  = is_last;
    res.frame_end = (cur_step == S_SUMN);
    case (cur_step)
      S_PRE0:  res.line_byte = PREAMBLE_FIRST;
      S_PRE1:  res.line_byte = PREAMBLE_SECOND;
      S_PRE2:  res.line_byte = PREAMBLE_THIRD;
      S_DATA:  res.line_byte = head_i.item.data_byte;
      S_DATAN: res.line_byte = ~head_i.item.data_byte;
      S_SUM:   res.line_byte = head_i.sum;
      S_SUMN:  res.line_byte = ~head_i.sum;
      default: res.line_byte = PREAMBLE_THIRD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_PRE0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
        if (is_last) begin
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          step_q    <= step_e'(3'(cur_step) + 3'd1);
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  // the complemented checksum always closes the run of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.run_last)
    else $error("frame end without run end");

  // retiring a command leaves its last result in the slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> out_valid_q && out_q.run_last)
    else $error("command retired without a final result");

  // preamble steps only run for a command byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q && (step_q == S_PRE1 || step_q == S_PRE2)
      |-> head_i.item.opens_message)
    else $error("preamble step on a byte that opens no message");
`endif

endmodule : cbfe_back

`default_nettype wire

### rtl/complemented_byte_frame_encoder.sv
// ----------------------------------------------------------------------------
// complemented_byte_frame_encoder
// Frames message bytes for the infrared line: preamble, byte/complement
// pairs and a checksum pair.
// ----------------------------------------------------------------------------
// Each accepted byte gives 2 to 7 line bytes: the preamble 55 FF 00 when it
// opens a message, then the byte and its complement, then the running sum and
// its complement when it closes the message. The result side delivers one line
// byte per cycle while the receiver keeps popping; the sequencer in the back
// part walks each byte's steps. A two-entry command queue lets the input take
// further bytes while earlier ones are still being sent, and the running sum is
// updated when a byte is taken in.
`default_nettype none

module complemented_byte_frame_encoder import cbfe_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  wire       pop,
  output out_item_t out_item_o
);

  logic      cmd_push;
  logic      cmd_pop;
  cmd_t      cmd_in;
  cmd_t      cmd_head;
  q_status_t q_status;

  cbfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  cbfe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_push),
    .cmd_i    (cmd_in),
    .pop_i    (cmd_pop),
    .head_o   (cmd_head),
    .status_o (q_status)
  );

  cbfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (cmd_head),
    .q_status_i (q_status),
    .cmd_pop_o  (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule : complemented_byte_frame_encoder

`default_nettype wire

### tb/complemented_byte_frame_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complemented_byte_frame_encoder_test
// Self-checking bench for the complemented byte frame encoder.
// ----------------------------------------------------------------------------
// Message bytes go in through the push/full side. A local encoder model turns
// each accepted request into the line bytes it should produce and queues them.
// Every line byte taken through the empty/pop side is checked against the
// oldest queued byte. The run covers corner bytes first, then random messages
// with sender gaps and receiver stalls in several mixes.
// ----------------------------------------------------------------------------

module complemented_byte_frame_encoder_test;
  import cbfe_pkg::*;

  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned ITEMS_PER_PHASE = 36;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  // percent of cycles each side holds off
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  logic [7:0]  message_sum = '0;
  out_item_t   line_bytes_due[$];
  int unsigned mismatch_count = 0;

  complemented_byte_frame_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expand one accepted byte into the line bytes it causes.
  function automatic void encode_byte(in_item_t req);
    out_item_t ob;
    if (req.opens_message) begin
      ob = '{line_byte: PREAMBLE_FIRST, run_last: 1'b0, frame_end: 1'b0};
      line_bytes_due.push_back(ob);
      ob.line_byte = PREAMBLE_SECOND;
      line_bytes_due.push_back(ob);
      ob.line_byte = PREAMBLE_THIRD;
      line_bytes_due.push_back(ob);
      message_sum = req.data_byte;
    end else begin
      message_sum = message_sum + req.data_byte;
    end
    ob = '{line_byte: req.data_byte, run_last: 1'b0, frame_end: 1'b0};
    line_bytes_due.push_back(ob);
    ob = '{line_byte: ~req.data_byte, run_last: ~req.closes_message, frame_end: 1'b0};
    line_bytes_due.push_back(ob);
    if (req.closes_message) begin
      ob = '{line_byte: message_sum, run_last: 1'b0, frame_end: 1'b0};
      line_bytes_due.push_back(ob);
      ob = '{line_byte: ~message_sum, run_last: 1'b1, frame_end: 1'b1};
      line_bytes_due.push_back(ob);
    end
  endfunction

  // Receiver: stall at random.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every line byte taken from the block.
  always @(posedge clk_i) begin
    out_item_t due;
    if (rst_ni && pop && !empty) begin
      if (line_bytes_due.size() == 0) begin
        $error("unexpected line byte %0h", out_item_o.line_byte);
        mismatch_count++;
      end else begin
        due = line_bytes_due.pop_front();
        if (out_item_o.line_byte !== due.line_byte) begin
          $error("line_byte: expected %0h, got %0h", due.line_byte, out_item_o.line_byte);
          mismatch_count++;
        end
        if (out_item_o.run_last !== due.run_last) begin
          $error("run_last: expected %0b, got %0b", due.run_last, out_item_o.run_last);
          mismatch_count++;
        end
        if (out_item_o.frame_end !== due.frame_end) begin
          $error("frame_end: expected %0b, got %0b", due.frame_end, out_item_o.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_byte(logic [7:0] data, logic opens, logic closes);
    in_item_t req;
    req = '{data_byte: data, opens_message: opens, closes_message: closes};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (full);
    encode_byte(req);
  endtask

  task automatic wait_drained();
    while (line_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed messages with random content, some loose bytes.
  task automatic run_random_messages(int unsigned count);
    int unsigned sent;
    int unsigned params;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        params = $urandom_range(0, 4);
        send_byte(8'($urandom_range(0, 255)), 1'b1, params == 0);
        sent++;
        for (int unsigned i = 1; i <= params; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, i == params);
          sent++;
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic test_corner_bytes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // loose bytes right after reset add onto the cleared sum
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    // open and close on one byte, both extremes
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // sum keeps the checksum after a closed message
    send_byte(8'h80, 1'b0, 1'b1);
    // full message with wrapping sum
    send_byte(8'hA5, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    // open without close, then reopen restarts the sum
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b1);
  endtask

  task automatic test_free_flow();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_messages(ITEMS_PER_PHASE);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 59;
    recv_stall_pct = 0;
    run_random_messages(ITEMS_PER_PHASE);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    run_random_messages(ITEMS_PER_PHASE);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    run_random_messages(ITEMS_PER_PHASE / 2);
    // hold off until the block has delivered everything, then go on
    push <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    run_random_messages(ITEMS_PER_PHASE / 2);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_bytes();
    test_free_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    push <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (line_bytes_due.size() != 0) begin
      $error("%0d line bytes never arrived", line_bytes_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("complemented_byte_frame_encoder test passed");
    end else begin
      $display("complemented_byte_frame_encoder test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("complemented_byte_frame_encoder test failed");
    $finish;
  end

endmodule
